// ===== sv/alti_pkg.sv =====
// ----------------------------------------------------------------------------
// alti_pkg
// Shared types and constants of the arc-length table interpolator: table
// sizing, item structs, action and status codes, and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package alti_pkg;

    localparam int TABLE_DEPTH  = 1024;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
    localparam int DIST_W       = 32;
    localparam int FRAC_W       = 17;
    localparam int KEY_W        = DIST_W + 1;
    localparam int PROD_W       = DIST_W + FRAC_W;
    localparam int SEARCH_LIMIT = 64;
    localparam int FRAC_STEPS   = 16;
    localparam int STEP_W       = 6;

    localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        ACT_APPEND  = 2'd0,
        ACT_LEN2PAR = 2'd1,
        ACT_PAR2LEN = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [DIST_W-1:0] entry_distance;
        logic [FRAC_W-1:0] entry_param;
        logic [FRAC_W-1:0] query_value;
    } in_item_t;

    typedef struct packed {
        logic [FRAC_W-1:0] answer;
        logic [1:0]        status;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_APPEND,
        OP_CLEAR,
        OP_START_L2P,
        OP_START_P2L,
        OP_SAVE_DIST,
        OP_PROBE,
        OP_STEP,
        OP_INTERP_MUL,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_INTERP_SUM,
        OP_EXACT_D,
        OP_FRAC_LOAD,
        OP_RES_ZERO,
        OP_RES_ONE,
        OP_RES_EXACT_P,
        OP_RES_FULL,
        OP_RES_EMPTY,
        OP_RES_FRAC,
        OP_PUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       empty;
        logic       full;
        logic       q_ge_one;
        logic       beyond_last;
        logic       key_eq;
        logic       mid_last;
        logic       mid_zero;
        logic       between;
        logic       total_zero;
        logic       d_ge_total;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== sv/alti_dp.sv =====
// ----------------------------------------------------------------------------
// alti_dp
// Datapath: table memories, search bounds, shared multiplier, restoring
// divider, result assembly and the output register.
// ----------------------------------------------------------------------------
module alti_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  alti_pkg::ctrl_cmd_t  cmd,
    output alti_pkg::dp_stat_t   stat,
    input  alti_pkg::in_item_t   s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output alti_pkg::out_item_t  m_payload
);
    import alti_pkg::*;

    logic [DIST_W-1:0] dmem [TABLE_DEPTH];
    logic [FRAC_W-1:0] pmem [TABLE_DEPTH];

    in_item_t          item_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [DIST_W-1:0] total_reg;
    logic [IDX_W-1:0]  lo_reg, hi_reg;
    logic [DIST_W-1:0] d0_reg, d1_reg;
    logic [FRAC_W-1:0] p0_reg, p1_reg;
    logic [KEY_W-1:0]  dist_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DIST_W-1:0] den_reg;
    logic [DIST_W-1:0] base_reg;
    logic              neg_reg;
    logic [DIST_W-1:0] rem_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [DIST_W-1:0] d_reg;
    out_item_t         pend_reg;
    out_item_t         out_reg;
    logic              m_valid_reg;

    logic [IDX_W:0]    mid_sum;
    logic [IDX_W-1:0]  mid;
    logic [IDX_W-1:0]  last;
    logic [IDX_W-1:0]  raddr;
    logic [IDX_W-1:0]  raddr1;
    logic              is_l2p;
    logic [KEY_W-1:0]  key, a0, a1;
    logic [DIST_W-1:0] mul_a;
    logic [FRAC_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [KEY_W-1:0]  div_t;
    logic              div_bit;
    logic [DIST_W+1:0] sum_s;
    logic [FRAC_W-1:0] sum_clamp;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[IDX_W:1];
    assign last    = IDX_W'(count_reg - CNT_W'(1));
    assign raddr   = (cmd.op == OP_START_L2P) ? last : mid;
    assign raddr1  = raddr + IDX_W'(1);
    assign is_l2p  = (item_reg.action == ACT_LEN2PAR);

    // Both searches compare on a common key width.
    always_comb begin
        if (is_l2p) begin
            key = dist_reg;
            a0  = {1'b0, d0_reg};
            a1  = {1'b0, d1_reg};
        end else begin
            key = KEY_W'(item_reg.query_value);
            a0  = KEY_W'(p0_reg);
            a1  = KEY_W'(p1_reg);
        end
    end

    // One shared multiplier: length scaling at query start, then interpolation.
    always_comb begin
        if (cmd.op == OP_START_L2P) begin
            mul_a = total_reg;
            mul_b = item_reg.query_value;
        end else if (is_l2p) begin
            mul_a = dist_reg[DIST_W-1:0] - d0_reg;
            mul_b = (p1_reg < p0_reg) ? (p0_reg - p1_reg) : (p1_reg - p0_reg);
        end else begin
            mul_a = (d1_reg < d0_reg) ? (d0_reg - d1_reg) : (d1_reg - d0_reg);
            mul_b = item_reg.query_value - p0_reg;
        end
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign div_t   = {rem_reg, quo_reg[PROD_W-1]};
    assign div_bit = (div_t >= {1'b0, den_reg});

    always_comb begin
        if (neg_reg) begin
            sum_s = {2'b00, base_reg} - {2'b00, quo_reg[DIST_W-1:0]};
        end else begin
            sum_s = {2'b00, base_reg} + {2'b00, quo_reg[DIST_W-1:0]};
        end
        if (sum_s[DIST_W+1]) begin
            sum_clamp = '0;
        end else if (sum_s > (DIST_W+2)'(ONE_Q16)) begin
            sum_clamp = ONE_Q16;
        end else begin
            sum_clamp = sum_s[FRAC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_APPEND) begin
            dmem[count_reg[IDX_W-1:0]] <= item_reg.entry_distance;
            pmem[count_reg[IDX_W-1:0]] <= item_reg.entry_param;
        end
        d0_reg <= dmem[raddr];
        d1_reg <= dmem[raddr1];
        p0_reg <= pmem[raddr];
        p1_reg <= pmem[raddr1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_APPEND) begin
                count_reg <= count_reg + CNT_W'(1);
                total_reg <= item_reg.entry_distance;
            end else if (cmd.op == OP_CLEAR) begin
                count_reg <= '0;
                total_reg <= '0;
            end
            if (cmd.op == OP_PUSH) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                item_reg <= s_payload;
            end
            OP_APPEND, OP_CLEAR: begin
                pend_reg <= '{answer: '0, status: ST_OK};
            end
            OP_START_L2P: begin
                lo_reg   <= '0;
                hi_reg   <= last;
                prod_reg <= mul_p;
            end
            OP_START_P2L: begin
                lo_reg <= '0;
                hi_reg <= last;
            end
            OP_SAVE_DIST: begin
                dist_reg <= prod_reg[PROD_W-1:FRAC_W-1];
            end
            OP_STEP: begin
                if (a0 < key) begin
                    lo_reg <= mid;
                end else begin
                    hi_reg <= mid;
                end
            end
            OP_INTERP_MUL: begin
                prod_reg <= mul_p;
                if (is_l2p) begin
                    den_reg  <= d1_reg - d0_reg;
                    base_reg <= DIST_W'(p0_reg);
                    neg_reg  <= (p1_reg < p0_reg);
                end else begin
                    den_reg  <= DIST_W'(p1_reg - p0_reg);
                    base_reg <= d0_reg;
                    neg_reg  <= (d1_reg < d0_reg);
                end
            end
            OP_DIV_LOAD: begin
                rem_reg <= '0;
                quo_reg <= prod_reg;
            end
            OP_DIV_STEP: begin
                rem_reg <= div_bit ? DIST_W'(div_t - {1'b0, den_reg}) : div_t[DIST_W-1:0];
                quo_reg <= {quo_reg[PROD_W-2:0], div_bit};
            end
            OP_INTERP_SUM: begin
                if (is_l2p) begin
                    pend_reg <= '{answer: sum_clamp, status: ST_OK};
                end else begin
                    d_reg <= sum_s[DIST_W+1] ? '0 : sum_s[DIST_W-1:0];
                end
            end
            OP_EXACT_D: begin
                d_reg <= d0_reg;
            end
            OP_FRAC_LOAD: begin
                // Remainder starts at the distance, so only the fraction bits remain.
                rem_reg <= d_reg;
                quo_reg <= '0;
                den_reg <= total_reg;
            end
            OP_RES_ZERO: begin
                pend_reg <= '{answer: '0, status: ST_OK};
            end
            OP_RES_ONE: begin
                pend_reg <= '{answer: ONE_Q16, status: ST_OK};
            end
            OP_RES_EXACT_P: begin
                pend_reg <= '{answer: (p0_reg > ONE_Q16) ? ONE_Q16 : p0_reg, status: ST_OK};
            end
            OP_RES_FULL: begin
                pend_reg <= '{answer: '0, status: ST_FULL};
            end
            OP_RES_EMPTY: begin
                pend_reg <= '{answer: '0, status: ST_EMPTY};
            end
            OP_RES_FRAC: begin
                pend_reg <= '{answer: FRAC_W'(quo_reg[FRAC_STEPS-1:0]), status: ST_OK};
            end
            OP_PUSH: begin
                out_reg <= pend_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        stat.action      = item_reg.action;
        stat.empty       = (count_reg == '0);
        stat.full        = (count_reg == CNT_W'(TABLE_DEPTH));
        stat.q_ge_one    = (item_reg.query_value >= ONE_Q16);
        stat.beyond_last = (prod_reg[PROD_W-1:FRAC_W-1] > {1'b0, d0_reg});
        stat.key_eq      = (a0 == key);
        stat.mid_last    = (mid == last);
        stat.mid_zero    = (mid == '0);
        stat.between     = (a0 <= key) && (key <= a1);
        stat.total_zero  = (total_reg == '0);
        stat.d_ge_total  = (d_reg >= total_reg);
        stat.out_free    = !m_valid_reg || m_ready;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");
    a_no_append_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_APPEND |-> count_reg != CNT_W'(TABLE_DEPTH))
        else $error("append issued on a full table");
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_PUSH |-> (!m_valid_reg || m_ready))
        else $error("result pushed over an untaken transaction");
    a_push_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_PUSH |=> m_valid_reg)
        else $error("pushed result not presented");
`endif

endmodule

// ===== sv/alti_ctrl.sv =====
// ----------------------------------------------------------------------------
// alti_ctrl
// Controller: sequences dispatch, binary search probes, interpolation
// divide, fraction divide and result hand-off through datapath commands.
// ----------------------------------------------------------------------------
module alti_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  alti_pkg::dp_stat_t  stat,
    output alti_pkg::ctrl_cmd_t cmd
);
    import alti_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_DISP  = 13'b0000000000010,
        S_RANGE = 13'b0000000000100,
        S_PROBE = 13'b0000000001000,
        S_EVAL  = 13'b0000000010000,
        S_DIVLD = 13'b0000000100000,
        S_DIV   = 13'b0000001000000,
        S_SUM   = 13'b0000010000000,
        S_FRAC  = 13'b0000100000000,
        S_FDIV  = 13'b0001000000000,
        S_FRES  = 13'b0010000000000,
        S_PUSH  = 13'b0100000000000,
        S_SPARE = 13'b1000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                cnt_next   = '0;
                state_next = S_PUSH;
                unique case (action_t'(stat.action))
                    ACT_APPEND: cmd.op = stat.full ? OP_RES_FULL : OP_APPEND;
                    ACT_CLEAR:  cmd.op = OP_CLEAR;
                    ACT_LEN2PAR: begin
                        if (stat.empty) begin
                            cmd.op = OP_RES_EMPTY;
                        end else begin
                            cmd.op     = OP_START_L2P;
                            state_next = S_RANGE;
                        end
                    end
                    ACT_PAR2LEN: begin
                        priority if (stat.empty) begin
                            cmd.op = OP_RES_EMPTY;
                        end else if (stat.q_ge_one) begin
                            cmd.op = OP_RES_ONE;
                        end else begin
                            cmd.op     = OP_START_P2L;
                            state_next = S_PROBE;
                        end
                    end
                    default: cmd.op = OP_NONE;
                endcase
            end
            S_RANGE: begin
                if (stat.beyond_last) begin
                    cmd.op     = OP_RES_ONE;
                    state_next = S_PUSH;
                end else begin
                    cmd.op     = OP_SAVE_DIST;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                cmd.op     = OP_PROBE;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                state_next = S_PUSH;
                priority if (stat.key_eq) begin
                    if (stat.action == ACT_LEN2PAR) begin
                        cmd.op = OP_RES_EXACT_P;
                    end else begin
                        cmd.op     = OP_EXACT_D;
                        state_next = S_FRAC;
                    end
                end else if (stat.mid_last) begin
                    cmd.op = OP_RES_ONE;
                end else if (stat.mid_zero) begin
                    cmd.op = OP_RES_ZERO;
                end else if (stat.between) begin
                    cmd.op     = OP_INTERP_MUL;
                    state_next = S_DIVLD;
                end else if (cnt_reg == STEP_W'(SEARCH_LIMIT - 1)) begin
                    // The search gave up without bracketing the key.
                    cmd.op = OP_RES_ZERO;
                end else begin
                    cmd.op     = OP_STEP;
                    cnt_next   = cnt_reg + STEP_W'(1);
                    state_next = S_PROBE;
                end
            end
            S_DIVLD: begin
                cmd.op     = OP_DIV_LOAD;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(PROD_W - 1)) begin
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                cmd.op     = OP_INTERP_SUM;
                state_next = (stat.action == ACT_LEN2PAR) ? S_PUSH : S_FRAC;
            end
            S_FRAC: begin
                cnt_next   = '0;
                state_next = S_PUSH;
                priority if (stat.total_zero) begin
                    cmd.op = OP_RES_ZERO;
                end else if (stat.d_ge_total) begin
                    cmd.op = OP_RES_ONE;
                end else begin
                    cmd.op     = OP_FRAC_LOAD;
                    state_next = S_FDIV;
                end
            end
            S_FDIV: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(FRAC_STEPS - 1)) begin
                    state_next = S_FRES;
                end
            end
            S_FRES: begin
                cmd.op     = OP_RES_FRAC;
                state_next = S_PUSH;
            end
            S_PUSH: begin
                if (stat.out_free) begin
                    cmd.op     = OP_PUSH;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_LOAD |-> state_reg == S_IDLE)
        else $error("transaction loaded outside idle");
    a_load_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_LOAD |=> state_reg == S_DISP)
        else $error("loaded transaction not dispatched");
    a_push_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_PUSH |=> state_reg == S_IDLE)
        else $error("controller did not return to idle after result");
`endif

endmodule

// ===== sv/arc_length_table_interpolator_core.sv =====
// A query runs a binary search and, when it interpolates, the restoring divider; a
// parameter-to-length query may add a fraction divide. An ordered 1024-entry table needs
// at most 11 probes; an unordered one runs up to 64 probes before the search gives up.
// One transaction at a time: the next is accepted only after the result is registered
// for output. Synchronous reset empties the table and drops any presented result.
// ----------------------------------------------------------------------------
// arc_length_table_interpolator_core
// Appendable (distance, parameter) table with binary-search lookup and
// linear interpolation between neighboring entries in either direction.
// ----------------------------------------------------------------------------
module arc_length_table_interpolator_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  alti_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output alti_pkg::out_item_t m_payload
);
    import alti_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    alti_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    alti_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc-length table interpolator testbench
// Drives appends, clears and queries in both directions through the input
// channel, predicts every answer and status in step with the accepted input,
// and compares each result against the oldest predicted one. Both sides idle
// in random bursts, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    import alti_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_payload;

    arc_length_table_interpolator_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    always #5 aclk = ~aclk;

    // Predictor state
    logic [31:0] tbl_dist [TABLE_DEPTH];
    logic [16:0] tbl_param [TABLE_DEPTH];
    int unsigned tbl_count = 0;
    logic [31:0] curve_len = 0;

    in_item_t  pending_items [$];
    out_item_t expected_results [$];
    int  errors = 0;
    int  n_results = 0;
    int  n_queries = 0;
    int  n_full = 0;
    bit  calm = 0;       // no idling in the last part
    longint cycle = 0;

    function automatic logic [16:0] sat_one(longint v);
        if (v < 0) return 0;
        if (v > 65536) return 17'h10000;
        return v[16:0];
    endfunction

    function automatic logic [16:0] to_fraction(longint unsigned d);
        longint unsigned f;
        if (curve_len == 0) return 0;
        f = (d << 16) / curve_len;
        return (f > 65536) ? 17'h10000 : f[16:0];
    endfunction

    function automatic logic [16:0] len_to_param(logic [16:0] frac);
        longint unsigned scaled_len;
        int unsigned last, lo, hi, mid;
        longint d0, d1, num, den, dlt;
        scaled_len = (longint'(frac) * longint'(curve_len)) >> 16;
        last = tbl_count - 1;
        lo = 0;
        hi = last;
        if (scaled_len > tbl_dist[last]) return 17'h10000;
        for (int it = 0; it < SEARCH_LIMIT; it++) begin
            mid = (lo + hi) / 2;
            d0 = tbl_dist[mid];
            if (d0 == scaled_len) return sat_one(tbl_param[mid]);
            if (mid == last) return 17'h10000;
            if (mid == 0) return 0;
            d1 = tbl_dist[mid+1];
            if (d0 <= scaled_len && scaled_len <= d1) begin
                num = scaled_len - d0;
                den = d1 - d0;
                dlt = longint'(tbl_param[mid+1]) - longint'(tbl_param[mid]);
                return sat_one(longint'(tbl_param[mid]) + dlt * num / den);
            end
            if (d0 < scaled_len) lo = mid; else hi = mid;
        end
        return 0;
    endfunction

    function automatic logic [16:0] param_to_len(logic [16:0] t);
        int unsigned last, lo, hi, mid;
        longint p0, p1, num, den, dlt, d;
        last = tbl_count - 1;
        lo = 0;
        hi = last;
        if (t >= 65536) return 17'h10000;
        for (int it = 0; it < SEARCH_LIMIT; it++) begin
            mid = (lo + hi) / 2;
            p0 = tbl_param[mid];
            if (p0 == t) return to_fraction(tbl_dist[mid]);
            if (mid == last) return 17'h10000;
            if (mid == 0) return 0;
            p1 = tbl_param[mid+1];
            if (p0 <= t && t <= p1) begin
                num = t - p0;
                den = p1 - p0;
                dlt = longint'(tbl_dist[mid+1]) - longint'(tbl_dist[mid]);
                d = longint'(tbl_dist[mid]) + dlt * num / den;
                return to_fraction(d < 0 ? 0 : d);
            end
            if (p0 < t) lo = mid; else hi = mid;
        end
        return 0;
    endfunction

    function automatic out_item_t predict_item(in_item_t it);
        out_item_t r;
        r.answer = 0;
        r.status = ST_OK;
        case (action_t'(it.action))
            ACT_APPEND: begin
                if (tbl_count < TABLE_DEPTH) begin
                    tbl_dist[tbl_count] = it.entry_distance;
                    tbl_param[tbl_count] = it.entry_param;
                    tbl_count++;
                    curve_len = it.entry_distance;
                end else begin
                    r.status = ST_FULL;
                end
            end
            ACT_CLEAR: begin
                tbl_count = 0;
                curve_len = 0;
            end
            default: begin
                if (tbl_count == 0) r.status = ST_EMPTY;
                else if (it.action == ACT_LEN2PAR) r.answer = len_to_param(it.query_value);
                else r.answer = param_to_len(it.query_value);
            end
        endcase
        return r;
    endfunction

    // Item builders for the stimulus
    function automatic in_item_t mk(action_t a, logic [31:0] d, logic [16:0] p,
                                    logic [16:0] q);
        in_item_t it;
        it.action = a;
        it.entry_distance = d;
        it.entry_param = p;
        it.query_value = q;
        return it;
    endfunction

    task automatic queue_item(in_item_t it);
        pending_items = {pending_items, it};
    endtask

    function automatic logic [16:0] rnd_frac();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 17'h10000;
            2: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic add_query();
        queue_item(mk($urandom_range(0, 1) ? ACT_LEN2PAR : ACT_PAR2LEN,
                      $urandom, 17'($urandom), rnd_frac()));
    endtask

    // Driver
    int src_gap = 0;
    always @(posedge aclk) begin
        out_item_t pred;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pred = predict_item(s_payload);
                expected_results = {expected_results, pred};
                if (s_payload.action inside {ACT_LEN2PAR, ACT_PAR2LEN}) n_queries++;
                if (pred.status == ST_FULL) n_full++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    src_gap <= $urandom_range(0, 10);
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_payload <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold, started once after a few hundred results
    int hold_cnt = 0;
    bit hold_active = 0;
    bit hold_done = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!hold_done && n_results >= 300) begin
                hold_cnt <= 400;
                hold_active <= 1'b1;
                hold_done <= 1'b1;
            end else if (hold_cnt > 1) begin
                hold_cnt <= hold_cnt - 1;
            end else if (hold_active) begin
                hold_cnt <= 0;
                hold_active <= 1'b0;
            end
        end
    end

    // Monitor and receiver stalls
    int sink_gap = 0;
    always @(posedge aclk) begin
        out_item_t exp_r;
        cycle <= cycle + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result answer=%0d status=%0d", $time,
                             m_payload.answer, m_payload.status);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_payload.answer !== exp_r.answer) begin
                        $display("%0t: answer expected %0d actual %0d", $time,
                                 exp_r.answer, m_payload.answer);
                        errors++;
                    end
                    if (m_payload.status !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_r.status, m_payload.status);
                        errors++;
                    end
                end
            end
            if (hold_active) begin
                m_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(0, 10);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Limit: about 1250 items at their worst-case search length plus idling and the
    // long hold, taken several times over.
    always @(posedge aclk) begin
        if (cycle > 900000) begin
            $display("Timed out at cycle %0d", cycle);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int unsigned n, d, p;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty table, single entry, edge fractions, unordered table
        queue_item(mk(ACT_LEN2PAR, 0, 0, 17'h08000));
        queue_item(mk(ACT_PAR2LEN, 0, 0, 0));
        queue_item(mk(ACT_APPEND, 0, 0, 0));
        queue_item(mk(ACT_LEN2PAR, 0, 0, 0));
        queue_item(mk(ACT_PAR2LEN, 0, 0, 17'h00100));
        queue_item(mk(ACT_APPEND, 32'h0001_0000, 17'h04000, 0));
        queue_item(mk(ACT_APPEND, 32'h0003_0000, 17'h0C000, 0));
        queue_item(mk(ACT_APPEND, 32'hFFFF_FFFF, 17'h10000, 0));
        queue_item(mk(ACT_LEN2PAR, 0, 0, 17'h10000));
        queue_item(mk(ACT_LEN2PAR, 0, 0, 17'h1FFFF));
        queue_item(mk(ACT_LEN2PAR, 0, 0, 17'h00001));
        queue_item(mk(ACT_PAR2LEN, 0, 0, 17'h08000));
        queue_item(mk(ACT_PAR2LEN, 0, 0, 17'h0C000));
        queue_item(mk(ACT_PAR2LEN, 0, 0, 17'h10000));
        queue_item(mk(ACT_APPEND, 32'h0000_1000, 17'h1FFFF, 0));
        queue_item(mk(ACT_LEN2PAR, 0, 0, 17'h00800));
        queue_item(mk(ACT_PAR2LEN, 0, 0, 17'h0FFFF));
        queue_item(mk(ACT_CLEAR, 32'hFFFF_FFFF, 17'h1FFFF, 17'h1FFFF));
        queue_item(mk(ACT_PAR2LEN, 0, 0, 17'h00010));

        // Fill the table past its depth once to see the full status
        d = 0;
        for (int i = 0; i < TABLE_DEPTH + 3; i++) begin
            d += $urandom_range(0, 4000);
            queue_item(mk(ACT_APPEND, d, 17'((i * 64) & 17'h1FFFF), 0));
        end
        for (int i = 0; i < 30; i++) add_query();
        queue_item(mk(ACT_CLEAR, 0, 0, 0));

        // Random: mostly well-formed monotonic tables with queries, some noise
        n = pending_items.size();
        while (n < 1250) begin
            int len;
            len = $urandom_range(1, 12);
            d = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1000);
            p = $urandom_range(0, 2000);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0)
                    queue_item(mk(ACT_APPEND, $urandom, 17'($urandom), 17'($urandom)));
                else
                    queue_item(mk(ACT_APPEND, d, 17'(p), 17'($urandom)));
                d += ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 200000);
                p += ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12000);
                if (p > 65536) p = 65536;
                n++;
            end
            for (int i = $urandom_range(2, 10); i > 0; i--) begin
                add_query();
                n++;
            end
            queue_item(mk(ACT_CLEAR, $urandom, 17'($urandom), 17'($urandom)));
            n++;
        end

        // The last stretch runs without idling on either side.
        while (pending_items.size() > 150) @(posedge aclk);
        calm = 1;

        while (pending_items.size() > 0 || s_valid) @(posedge aclk);
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Covered %0d results, %0d queries, %0d table-full drops checked.",
                 n_results, n_queries, n_full);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
